### rtl/ftf_pkg.sv
// ----------------------------------------------------------------------------
// Float to fixed converter package
// Format codes, format tables and the records that pass between the
// pipeline stages of the converter.
// ----------------------------------------------------------------------------
package ftf_pkg;

   localparam int FLOAT_W = 32;
   localparam int CODE_W  = 32;
   localparam int EXP_W   = 8;
   localparam int MANT_W  = 23;
   localparam int SIG_W   = MANT_W + 1;
   // Largest integer field of any format.
   localparam int IPART_W = 15;
   // Width of the saturated right shift amount, which stops at 48.
   localparam int RSH_W   = 6;

   typedef enum logic [1:0] {
      FMT_Q15_16 = 2'd0,
      FMT_Q3_12  = 2'd1,
      FMT_Q3_6   = 2'd2,
      FMT_Q1_6   = 2'd3
   } fmt_type;

   localparam fmt_type FMT_RESET = FMT_Q3_12;

   // Number of integer bits of a format.
   function automatic logic [3:0] fmt_int_bits(input fmt_type fmt);
      logic [3:0] bits;
      unique case (fmt)
         FMT_Q15_16: bits = 4'd15;
         FMT_Q3_12:  bits = 4'd3;
         FMT_Q3_6:   bits = 4'd3;
         FMT_Q1_6:   bits = 4'd1;
         default:    bits = 4'd0;
      endcase
      return bits;
   endfunction

   // Mask of the bits that make up a code of the format.
   function automatic logic [CODE_W-1:0] fmt_code_mask(input fmt_type fmt);
      logic [CODE_W-1:0] mask;
      unique case (fmt)
         FMT_Q15_16: mask = 32'hFFFF_FFFF;
         FMT_Q3_12:  mask = 32'h0000_FFFF;
         FMT_Q3_6:   mask = 32'h0000_03FF;
         FMT_Q1_6:   mask = 32'h0000_00FF;
         default:    mask = '0;
      endcase
      return mask;
   endfunction

   // Decoded float.
   typedef struct packed {
      logic              neg;
      logic              special;
      logic              ovf;
      logic              left;
      logic              lzero;
      logic [3:0]        lsh;
      logic [RSH_W-1:0]  rsh;
      logic [SIG_W-1:0]  sig;
   } dec_type;

   // Aligned magnitude: integer bits, truncated fraction and rounding bits.
   typedef struct packed {
      logic               neg;
      logic               special;
      logic               ovf;
      logic [IPART_W-1:0] ipart;
      logic [MANT_W-1:0]  q;
      logic               rbit;
      logic               sticky;
   } aln_type;

   // Magnitude code at the format width.
   typedef struct packed {
      logic              neg;
      logic              special;
      logic              ovf;
      logic [CODE_W-1:0] mag;
   } rnd_type;

endpackage

### rtl/ftf_if.sv
// ----------------------------------------------------------------------------
// Float to fixed converter channels
// Valid/ready channels for the float input items and the fixed-point
// result items.
// ----------------------------------------------------------------------------
interface ftf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] float_bits;

   modport source (output valid, output float_bits, input ready);
   modport sink   (input valid, input float_bits, output ready);
endinterface

interface ftf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] fixed_code;
   logic        overflow;

   modport source (output valid, output fixed_code, output overflow, input ready);
   modport sink   (input valid, input fixed_code, input overflow, output ready);
endinterface

### rtl/ftf_decode.sv
// ----------------------------------------------------------------------------
// Decode stage
// Splits the float, flags non-finite inputs and overflow, and works out
// the shift that aligns the significand to the binary point.
// ----------------------------------------------------------------------------
module ftf_decode import ftf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  fmt_type             fmt,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [FLOAT_W-1:0]  float_bits,
   output logic                out_valid,
   input  logic                out_ready,
   output dec_type             out_data
);

   localparam logic [EXP_W:0]   EXP_BIAS    = 9'd127;
   // Exponent at which the significand LSB has weight one.
   localparam logic [EXP_W-1:0] EXP_INT_LSB = 8'd150;
   localparam logic [EXP_W-1:0] SUBNORM_RSH = 8'd149;
   localparam logic [EXP_W-1:0] EXP_SPECIAL = 8'd255;
   localparam logic [EXP_W-1:0] LSH_LIMIT   = 8'd15;
   localparam logic [EXP_W-1:0] RSH_LIMIT   = 8'd48;

   logic                valid_ff;
   dec_type             data_ff;
   dec_type             data_in;
   logic [EXP_W-1:0]    ex;
   logic                ex_nz;
   logic [EXP_W-1:0]    lsh_full;
   logic [EXP_W-1:0]    rsh_full;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      ex       = float_bits[FLOAT_W-2:MANT_W];
      ex_nz    = |ex;
      lsh_full = ex - EXP_INT_LSB;
      rsh_full = ex_nz ? (EXP_INT_LSB - ex) : SUBNORM_RSH;

      data_in.neg     = float_bits[FLOAT_W-1];
      data_in.special = (ex == EXP_SPECIAL);
      data_in.ovf     = data_in.special ||
                        (ex_nz && ({1'b0, ex} >= EXP_BIAS + {5'b0, fmt_int_bits(fmt)}));
      data_in.left    = (ex >= EXP_INT_LSB);
      // Shifted left by the integer field width or more, no integer bit survives.
      data_in.lzero   = (lsh_full >= LSH_LIMIT);
      data_in.lsh     = lsh_full[3:0];
      data_in.rsh     = (rsh_full > RSH_LIMIT) ? RSH_LIMIT[RSH_W-1:0] : rsh_full[RSH_W-1:0];
      data_in.sig     = {ex_nz, float_bits[MANT_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/ftf_align.sv
// ----------------------------------------------------------------------------
// Align stage
// Shifts the significand into integer bits, a 23-bit fraction and the
// round and sticky bits below it.
// ----------------------------------------------------------------------------
module ftf_align import ftf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output aln_type out_data
);

   localparam int WIDE_W = SIG_W + 48;

   logic                    valid_ff;
   aln_type                 data_ff;
   aln_type                 data_in;
   logic [WIDE_W-1:0]       wide;
   logic [IPART_W+SIG_W-1:0] left_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // The significand sits 48 bits above the point: the integer part is on
      // top, then the fraction, then 25 bits that only feed the rounding.
      wide     = {in_data.sig, 48'b0} >> in_data.rsh;
      left_val = {{IPART_W{1'b0}}, in_data.sig} << in_data.lsh;

      data_in.neg     = in_data.neg;
      data_in.special = in_data.special;
      data_in.ovf     = in_data.ovf;
      if (in_data.left) begin
         data_in.ipart  = in_data.lzero ? '0 : left_val[IPART_W-1:0];
         data_in.q      = '0;
         data_in.rbit   = 1'b0;
         data_in.sticky = 1'b0;
      end else begin
         data_in.ipart  = wide[48+IPART_W-1:48];
         data_in.q      = wide[47:25];
         data_in.rbit   = wide[24];
         data_in.sticky = |wide[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/ftf_round.sv
// ----------------------------------------------------------------------------
// Round stage
// Rounds the fraction to nearest even and packs the integer and fraction
// fields of the selected format into a magnitude code.
// ----------------------------------------------------------------------------
module ftf_round import ftf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  fmt_type fmt,
   input  logic    in_valid,
   output logic    in_ready,
   input  aln_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rnd_type out_data
);

   logic              valid_ff;
   rnd_type           data_ff;
   rnd_type           data_in;
   logic              inc;
   logic [MANT_W:0]   q_sum;
   logic [MANT_W-1:0] qf;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      inc   = in_data.rbit && (in_data.sticky || in_data.q[0]);
      q_sum = {1'b0, in_data.q} + {{MANT_W{1'b0}}, inc};
      // A carry out of the fraction means 1.0: the fraction becomes zero and
      // the integer part stays as it is.
      qf    = q_sum[MANT_W] ? '0 : q_sum[MANT_W-1:0];

      data_in.neg     = in_data.neg;
      data_in.special = in_data.special;
      data_in.ovf     = in_data.ovf;
      unique case (fmt)
         FMT_Q15_16: data_in.mag = {1'b0, in_data.ipart, qf[22:7]};
         FMT_Q3_12:  data_in.mag = {16'b0, 1'b0, in_data.ipart[2:0], qf[22:11]};
         FMT_Q3_6:   data_in.mag = {22'b0, 1'b0, in_data.ipart[2:0], qf[22:17]};
         FMT_Q1_6:   data_in.mag = {24'b0, 1'b0, in_data.ipart[0], qf[22:17]};
         default:    data_in.mag = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/ftf_sign.sv
// ----------------------------------------------------------------------------
// Sign stage
// Applies the sign in two's complement at the format width, zeroes non-finite
// inputs and holds the finished result item in the output register.
// ----------------------------------------------------------------------------
module ftf_sign import ftf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  fmt_type           fmt,
   input  logic              in_valid,
   output logic              in_ready,
   input  rnd_type           in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CODE_W-1:0] fixed_code,
   output logic              overflow
);

   logic              valid_ff;
   logic [CODE_W-1:0] code_ff;
   logic [CODE_W-1:0] code_in;
   logic              ovf_ff;
   logic [CODE_W-1:0] signed_mag;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign fixed_code = code_ff;
   assign overflow   = ovf_ff;

   always_comb begin
      signed_mag = in_data.neg ? ('0 - in_data.mag) : in_data.mag;
      code_in    = in_data.special ? '0 : (signed_mag & fmt_code_mask(fmt));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         code_ff <= code_in;
         ovf_ff  <= in_data.ovf;
      end
   end

endmodule

### rtl/float_to_fixed_converter.sv
// ----------------------------------------------------------------------------
// Float to fixed converter
// Converts IEEE single-precision bit patterns to signed fixed-point codes
// in a selectable format.
// ----------------------------------------------------------------------------
// The converter takes one item per clock cycle unless the result side stalls,
// and returns each result through a pipeline of decode, align, round
// and sign stages. Every stage has its own valid bit and takes a new item
// whenever it is empty or its successor takes its item, so a stall on the
// result side fills bubbles first and holds items without loss. The format
// register resets to Q3.12 and must only be written while no item is in
// flight.
module float_to_fixed_converter import ftf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ftf_req_if.sink          req_ch,
   ftf_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);

   fmt_type csr_format_ff;
   fmt_type csr_format_in;

   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    aln_valid;
   logic    aln_ready;
   aln_type aln_data;
   logic    rnd_valid;
   logic    rnd_ready;
   rnd_type rnd_data;

   assign csr_format_in = fmt_type'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_format_ff <= FMT_RESET;
      end else if (csr_wr_en) begin
         csr_format_ff <= csr_format_in;
      end
   end

   ftf_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .fmt        (csr_format_ff),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .float_bits (req_ch.float_bits),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_data   (dec_data)
   );

   ftf_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (aln_valid),
      .out_ready (aln_ready),
      .out_data  (aln_data)
   );

   ftf_round u_round (
      .clock     (clock),
      .reset     (reset),
      .fmt       (csr_format_ff),
      .in_valid  (aln_valid),
      .in_ready  (aln_ready),
      .in_data   (aln_data),
      .out_valid (rnd_valid),
      .out_ready (rnd_ready),
      .out_data  (rnd_data)
   );

   ftf_sign u_sign (
      .clock      (clock),
      .reset      (reset),
      .fmt        (csr_format_ff),
      .in_valid   (rnd_valid),
      .in_ready   (rnd_ready),
      .in_data    (rnd_data),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .fixed_code (rsp_ch.fixed_code),
      .overflow   (rsp_ch.overflow)
   );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Float to fixed converter testbench
// Streams single-precision bit patterns through the converter in all four
// fixed-point formats. Each accepted item is converted by a local predictor,
// and every result item is checked against the oldest prediction, while both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb;
   import ftf_pkg::*;

   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 175;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [31:0] float_bits;
      fmt_type     fmt;
      logic [31:0] code;
      logic        ovf;
   } conversion_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_wr_data;

   ftf_req_if req_if ();
   ftf_rsp_if rsp_if ();

   float_to_fixed_converter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [31:0]    float_queue[$];
   conversion_type expected_codes[$];
   fmt_type        fmt_now;
   logic           calm = 1'b0;
   int             send_gap = 0;
   int             stall_left = 0;
   int             idle_cycles = 0;
   int             mismatches = 0;
   int             results_seen = 0;
   int             overflows_seen = 0;
   int             fmt_count[4] = '{0, 0, 0, 0};

   const fmt_type phase_fmt[NUM_PHASES] = '{FMT_Q15_16, FMT_Q1_6, FMT_Q3_6, FMT_Q3_12,
                                            FMT_Q1_6, FMT_Q15_16, FMT_Q3_6, FMT_Q1_6};

   // Zeros, infinities, NaNs, subnormals, wrap and overflow edges, a rounding
   // carry into 1.0 and a rounding tie.
   const logic [31:0] directed_floats[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
      32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
      32'h3F80_0000, 32'hBF80_0000, 32'h40E0_0000, 32'h4100_0000,
      32'hC100_0000, 32'h4130_0000, 32'h4188_0000, 32'h7F7F_FFFF,
      32'hFF7F_FFFF, 32'h3F7F_FFFF, 32'h3F00_0001, 32'h40FF_FFFF,
      32'hBE80_0000, 32'h4700_0000, 32'hC6FF_FE00, 32'h5F00_0000
   };

   // Divides by 2^r and rounds to nearest, ties to even.
   function automatic logic [31:0] round_half_even(input logic [31:0] v, input int r);
      logic [63:0] q, rem, half;
      if (r >= 32)
         return '0;
      q    = 64'(v) >> r;
      rem  = 64'(v) & ((64'd1 << r) - 64'd1);
      half = 64'd1 << (r - 1);
      if (rem > half || (rem == half && q[0]))
         q = q + 64'd1;
      return q[31:0];
   endfunction

   function automatic conversion_type fixed_of_float(input logic [31:0] x,
                                                     input fmt_type fmt);
      conversion_type rec;
      logic [7:0]  ex;
      logic [23:0] sig;
      logic [31:0] ipart, fsig, q, frac;
      logic [63:0] mag, code;
      int          e, s, width, ibits, fbits;
      case (fmt)
         FMT_Q15_16: begin width = 32; ibits = 15; fbits = 16; end
         FMT_Q3_12:  begin width = 16; ibits = 3;  fbits = 12; end
         FMT_Q3_6:   begin width = 10; ibits = 3;  fbits = 6;  end
         default:    begin width = 8;  ibits = 1;  fbits = 6;  end
      endcase
      rec.float_bits = x;
      rec.fmt        = fmt;
      ex = x[30:23];
      if (ex == 8'hFF) begin
         rec.code = '0;
         rec.ovf  = 1'b1;
         return rec;
      end
      sig     = (ex != 8'd0) ? {1'b1, x[22:0]} : {1'b0, x[22:0]};
      e       = (ex != 8'd0) ? int'(ex) - 150 : -149;
      rec.ovf = (ex != 8'd0) && (int'(ex) - 127 >= ibits);
      if (e >= 0) begin
         ipart = (e >= 32) ? '0 : 32'(64'(sig) << e);
         q     = '0;
      end else begin
         s = -e;
         if (s >= 24) begin
            ipart = '0;
            fsig  = 32'(sig);
         end else begin
            ipart = 32'(sig) >> s;
            fsig  = 32'(sig) & ((32'd1 << s) - 32'd1);
         end
         if (s <= 23)
            q = fsig << (23 - s);
         else
            q = round_half_even(fsig, s - 23);
      end
      // A fraction that rounds up to a whole one is dropped, not carried.
      if (q[31:23] != '0)
         q = '0;
      frac = {9'd0, q[22:0]} >> (23 - fbits);
      mag  = (64'(ipart & ((32'd1 << ibits) - 32'd1)) << fbits) | 64'(frac);
      code = x[31] ? 64'd0 - mag : mag;
      code = code & ((64'd1 << width) - 64'd1);
      rec.code = code[31:0];
      return rec;
   endfunction

   // Biased toward the exponents where the formats differ, the rounding
   // carry region and the special encodings.
   function automatic logic [31:0] pick_float();
      int         kind;
      logic [7:0] ex;
      logic [22:0] man;
      kind = $urandom_range(0, 99);
      man  = 23'($urandom);
      if (kind < 8) begin
         ex = 8'hFF;
         if (kind < 3)
            man = '0;
      end else if (kind < 16) begin
         ex = 8'h00;
      end else if (kind < 28) begin
         ex  = 8'($urandom_range(100, 126));
         man = 23'h7F_FFFF - 23'($urandom_range(0, 3));
      end else if (kind < 80) begin
         ex = 8'($urandom_range(110, 145));
      end else begin
         return $urandom;
      end
      return {1'($urandom_range(0, 1)), ex, man};
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic wait_idle();
      do
         @(negedge clock);
      while (float_queue.size() != 0 || req_if.valid || expected_codes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Driver: predicts each accepted item and presents the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            expected_codes.push_back(fixed_of_float(req_if.float_bits, fmt_now));
            fmt_count[fmt_now]++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (float_queue.size() != 0) begin
            req_if.valid      <= 1'b1;
            req_if.float_bits <= float_queue.pop_front();
            send_gap = calm ? 0 : idle_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result item and stalls the result channel.
   always @(posedge clock) begin
      conversion_type rec;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (rsp_if.overflow)
               overflows_seen++;
            if (expected_codes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: code %h ovf %b", rsp_if.fixed_code,
                           rsp_if.overflow);
            end else begin
               rec = expected_codes.pop_front();
               if (rsp_if.fixed_code !== rec.code || rsp_if.overflow !== rec.ovf) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: float %h %s expected code %h ovf %b, got code %h ovf %b",
                              rec.float_bits, rec.fmt.name(), rec.code, rec.ovf,
                              rsp_if.fixed_code, rsp_if.overflow);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20)
               stall_left = idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.float_bits = '0;
      rsp_if.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      fmt_now           = FMT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_floats[i])
         float_queue.push_back(directed_floats[i]);
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_fmt[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         @(negedge clock);
         fmt_now = phase_fmt[p];
         // Every third phase runs with both channels at full rate.
         calm = (p % 3 == 1);
         for (int i = 0; i < PHASE_ITEMS; i++)
            float_queue.push_back(pick_float());
      end
      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_codes.size() != 0)
         mismatches++;
      $display("Checked %0d results: %0d in Q15.16, %0d in Q3.12, %0d in Q3.6, %0d in Q1.6.",
               results_seen, fmt_count[FMT_Q15_16], fmt_count[FMT_Q3_12],
               fmt_count[FMT_Q3_6], fmt_count[FMT_Q1_6]);
      $display("%0d results carried the overflow flag; %0d failures found.",
               overflows_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/ftf_pkg.sv
rtl/ftf_if.sv
rtl/ftf_decode.sv
rtl/ftf_align.sv
rtl/ftf_round.sv
rtl/ftf_sign.sv
rtl/float_to_fixed_converter.sv
sim/tb.sv
